// ===== rtl/core/mvfu_pkg.sv =====
package mvfu_pkg;

  localparam int unsigned ADDR_W    = 17;  // entry address before the range check
  localparam int unsigned DATA_W    = 16;  // stored vx, vy and SAD width
  localparam int unsigned ENT_W     = 3 * DATA_W;
  localparam int unsigned VAL_W     = DATA_W + 1;  // signed view of one stored field
  localparam int unsigned WT_W      = 9;   // signed one-dimensional weight
  localparam int unsigned WW_W      = 2 * WT_W;
  localparam int unsigned PROD_W    = WW_W + VAL_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned RES_W     = 32;
  localparam int unsigned SAD_W     = 28;
  localparam int unsigned SAD_SHIFT = 4;
  localparam int unsigned NFIELD    = 3;
  localparam int unsigned NTAP      = 4;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPW       = $clog2(QDEPTH);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MAX_SRC_BLOCKS_DEF = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_NORM_SHIFT   = 3'd2,
    REG_DIVISOR      = 3'd3,
    REG_WEIGHT_TOTAL = 3'd4,
    REG_WEIGHT_ODD   = 3'd5,
    REG_WEIGHT_EVEN  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [7:0]  src_width;
    logic [7:0]  src_height;
    logic [4:0]  norm_shift;
    logic [15:0] divisor;
    logic [7:0]  weight_total;
    logic [7:0]  weight_odd;
    logic [7:0]  weight_even;
  } cfg_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic [13:0]                   src_index;
    logic [DATA_W-1:0]             load_vx;
    logic [DATA_W-1:0]             load_vy;
    logic [DATA_W-1:0]             load_sad;
    logic [NTAP-1:0][ADDR_W-1:0]   addr;
    logic                          odd_x;
    logic                          odd_y;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/core/mvfu_front.sv =====
module mvfu_front import mvfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [13:0] in_src_index,
  input  logic [15:0] in_load_vx,
  input  logic [15:0] in_load_vy,
  input  logic [15:0] in_load_sad,
  input  logic [9:0]  in_fine_col,
  input  logic [9:0]  in_fine_row,
  input  qstat_t      qs,
  output logic        push,
  output item_t       push_item
);

  logic              v_r, v_nxt;
  item_t             item_r, item_nxt;
  logic [7:0]        w, h;
  logic [8:0]        wlim, hlim;
  logic [9:0]        i, j;
  logic              col_edge, row_edge;
  logic [7:0]        ip, jp;
  logic [15:0]       base;
  logic [ADDR_W-1:0] nrow, ipn, a, b, c, d;

  // Clamp, find parent and neighbors, form the four entry addresses.
  always_comb begin
    w    = (cfg.src_width == 8'd0) ? 8'd1 : cfg.src_width;
    h    = (cfg.src_height == 8'd0) ? 8'd1 : cfg.src_height;
    wlim = {w, 1'b0} - 9'd1;
    hlim = {h, 1'b0} - 9'd1;
    i    = (in_fine_col > {1'b0, wlim}) ? {1'b0, wlim} : in_fine_col;
    j    = (in_fine_row > {1'b0, hlim}) ? {1'b0, hlim} : in_fine_row;
    col_edge = (i == 10'd0) || (i == {1'b0, wlim});
    row_edge = (j == 10'd0) || (j == {1'b0, hlim});
    ip   = i[8:1];
    jp   = j[8:1];
    base = 16'(jp) * 16'(w);
    nrow = j[0] ? ADDR_W'(base) + ADDR_W'(w) : ADDR_W'(base) - ADDR_W'(w);
    ipn  = i[0] ? ADDR_W'(ip) + ADDR_W'(1) : ADDR_W'(ip) - ADDR_W'(1);
    a    = ADDR_W'(ip) + ADDR_W'(base);
    b    = ipn + ADDR_W'(base);
    c    = ADDR_W'(ip) + nrow;
    d    = ipn + nrow;

    item_nxt.cmd       = cmd_t'(in_command);
    item_nxt.src_index = in_src_index;
    item_nxt.load_vx   = in_load_vx;
    item_nxt.load_vy   = in_load_vy;
    item_nxt.load_sad  = in_load_sad;
    item_nxt.odd_x     = i[0];
    item_nxt.odd_y     = j[0];
    if (col_edge && row_edge) begin
      item_nxt.addr = {a, a, a, a};
    end else if (col_edge) begin
      item_nxt.addr = {c, c, a, a};
    end else if (row_edge) begin
      item_nxt.addr = {b, b, a, a};
    end else begin
      item_nxt.addr = {d, c, b, a};
    end
  end

  assign in_stall  = v_r && qs.full;
  assign push      = v_r && !qs.full;
  assign push_item = item_r;
  assign v_nxt     = in_stall ? v_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/mvfu_queue.sv =====
module mvfu_queue import mvfu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  pop_item,
  output qstat_t qs
);

  item_t          buf_r [QDEPTH];
  logic [QPW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPW:0]   cnt_r, cnt_nxt;

  assign qs.full  = (cnt_r == (QPW+1)'(QDEPTH));
  assign qs.empty = (cnt_r == '0);
  assign pop_item = buf_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + QPW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QPW'(1) : rp_r;
    cnt_nxt = cnt_r + (QPW+1)'(push) - (QPW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/mvfu_div.sv =====
module mvfu_div import mvfu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [SUM_W-1:0] num,
  input  logic [DATA_W-1:0]       den,
  output logic                    out_valid,
  output logic [RES_W-1:0]        quot
);

  // One quotient bit per stage, restoring, on the magnitude.
  logic [SUM_W-1:0]  n_s [SUM_W+1];
  logic [SUM_W-1:0]  q_s [SUM_W+1];
  logic [DATA_W-1:0] r_s [SUM_W+1];
  logic [DATA_W-1:0] d_s [SUM_W+1];
  logic              neg_s [SUM_W+1];
  logic              v_s [SUM_W+1];
  logic [RES_W-1:0]  qm;

  assign neg_s[0] = num[SUM_W-1];
  assign n_s[0]   = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
  assign q_s[0]   = '0;
  assign r_s[0]   = '0;
  assign d_s[0]   = den;
  assign v_s[0]   = in_valid;

  for (genvar k = 0; k < SUM_W; k++) begin : g_stage
    logic [DATA_W:0] trial, diff;
    logic            ge;

    always_comb begin
      trial = {r_s[k], n_s[k][SUM_W-1]};
      diff  = trial - {1'b0, d_s[k]};
      ge    = (trial >= {1'b0, d_s[k]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_s[k+1]   <= n_s[k] << 1;
        q_s[k+1]   <= {q_s[k][SUM_W-2:0], ge};
        r_s[k+1]   <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        d_s[k+1]   <= d_s[k];
        neg_s[k+1] <= neg_s[k];
      end
    end
  end

  assign qm        = q_s[SUM_W][RES_W-1:0];
  assign quot      = neg_s[SUM_W] ? -qm : qm;
  assign out_valid = v_s[SUM_W];

endmodule

// ===== rtl/core/mvfu_back.sv =====
module mvfu_back import mvfu_pkg::*; #(
  parameter int unsigned MAX_SRC_BLOCKS = MAX_SRC_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  qstat_t             qs,
  input  item_t              pop_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RES_W-1:0]   out_vx,
  output logic [RES_W-1:0]   out_vy,
  output logic [SAD_W-1:0]   out_sad
);

  localparam int unsigned IDXW = $clog2(MAX_SRC_BLOCKS);

  logic [ENT_W-1:0] mem0 [MAX_SRC_BLOCKS];
  logic [ENT_W-1:0] mem1 [MAX_SRC_BLOCKS];

  logic                     adv;
  logic [ADDR_W-1:0]        widx;
  logic                     wr;
  logic [NTAP-1:0]          oor;
  logic signed [WT_W-1:0]   ax1, ay1, ax2, ay2;
  logic signed [WW_W-1:0]   wt [NTAP];

  logic                     v1_r, v2_r, v3_r;
  logic [ENT_W-1:0]         rd_r [NTAP];
  logic [NTAP-1:0]          oor_r;
  logic signed [WW_W-1:0]   wt_r [NTAP];
  logic signed [VAL_W-1:0]  val [NFIELD][NTAP];
  logic signed [PROD_W-1:0] p_r [NFIELD][NTAP];
  logic signed [SUM_W-1:0]  sum_r [NFIELD];
  logic [DATA_W-1:0]        den;
  logic [NFIELD-1:0]        dv;
  logic [RES_W-1:0]         q [NFIELD];
  logic signed [4:0]        sh;
  logic [4:0]               lsh;
  logic [RES_W-1:0]         vx_nxt, vy_nxt, sad_full;

  logic                     out_v_r;
  logic [RES_W-1:0]         out_vx_r, out_vy_r;
  logic [SAD_W-1:0]         out_sad_r;

  assign adv  = !out_v_r || !out_stall;
  assign pop  = adv && !qs.empty;
  assign widx = ADDR_W'(pop_item.src_index);
  assign wr   = pop && (pop_item.cmd == CMD_LOAD) && (widx < ADDR_W'(MAX_SRC_BLOCKS));

  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      oor[k] = (pop_item.addr[k] >= ADDR_W'(MAX_SRC_BLOCKS));
    end
    ax1   = $signed({1'b0, pop_item.odd_x ? cfg.weight_odd : cfg.weight_even});
    ay1   = $signed({1'b0, pop_item.odd_y ? cfg.weight_odd : cfg.weight_even});
    ax2   = $signed({1'b0, cfg.weight_total}) - ax1;
    ay2   = $signed({1'b0, cfg.weight_total}) - ay1;
    wt[0] = ax1 * ay1;
    wt[1] = ax2 * ay1;
    wt[2] = ax1 * ay2;
    wt[3] = ax2 * ay2;
  end

  // Two copies of the store, two read ports each; every load writes both.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem0[widx[IDXW-1:0]] <= {pop_item.load_vx, pop_item.load_vy, pop_item.load_sad};
    end
    if (adv) begin
      rd_r[0] <= mem0[pop_item.addr[0][IDXW-1:0]];
      rd_r[1] <= mem0[pop_item.addr[1][IDXW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem1[widx[IDXW-1:0]] <= {pop_item.load_vx, pop_item.load_vy, pop_item.load_sad};
    end
    if (adv) begin
      rd_r[2] <= mem1[pop_item.addr[2][IDXW-1:0]];
      rd_r[3] <= mem1[pop_item.addr[3][IDXW-1:0]];
    end
  end

  // Unpack entries; an address past the store reads zero.
  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      val[0][k] = oor_r[k] ? '0 : VAL_W'($signed(rd_r[k][3*DATA_W-1:2*DATA_W]));
      val[1][k] = oor_r[k] ? '0 : VAL_W'($signed(rd_r[k][2*DATA_W-1:DATA_W]));
      val[2][k] = oor_r[k] ? '0 : $signed({1'b0, rd_r[k][DATA_W-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pop && (pop_item.cmd == CMD_QUERY);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor_r <= oor;
      for (int k = 0; k < NTAP; k++) begin
        wt_r[k] <= wt[k];
      end
      for (int f = 0; f < NFIELD; f++) begin
        for (int k = 0; k < NTAP; k++) begin
          p_r[f][k] <= wt_r[k] * val[f][k];
        end
        sum_r[f] <= SUM_W'(p_r[f][0]) + SUM_W'(p_r[f][1])
                  + SUM_W'(p_r[f][2]) + SUM_W'(p_r[f][3]);
      end
    end
  end

  assign den = (cfg.divisor == '0) ? DATA_W'(1) : cfg.divisor;

  for (genvar f = 0; f < NFIELD; f++) begin : g_div
    mvfu_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (v3_r),
      .num       (sum_r[f]),
      .den       (den),
      .out_valid (dv[f]),
      .quot      (q[f])
    );
  end

  // Positive shift goes right with sign, otherwise left by its negation.
  always_comb begin
    sh  = $signed(cfg.norm_shift);
    lsh = 5'(-sh);
    if (sh > 5'sd0) begin
      vx_nxt = RES_W'($signed(q[0]) >>> sh[3:0]);
      vy_nxt = RES_W'($signed(q[1]) >>> sh[3:0]);
    end else begin
      vx_nxt = q[0] << lsh;
      vy_nxt = q[1] << lsh;
    end
    sad_full = RES_W'($signed(q[2]) >>> SAD_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= &dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vx_r  <= vx_nxt;
      out_vy_r  <= vy_nxt;
      out_sad_r <= sad_full[SAD_W-1:0];
    end
  end

  assign out_valid = out_v_r;
  assign out_vx    = out_vx_r;
  assign out_vy    = out_vy_r;
  assign out_sad   = out_sad_r;

endmodule

// ===== rtl/core/motion_vector_field_upsample.sv =====
// Upsamples a coarse motion-vector field by two. Load beats (in_command = 0) write one
// source entry (vx, vy, SAD) at in_src_index; query beats (in_command = 1) name a fine
// block whose bilinear blend of its parent and the neighbors on its parity side comes
// back as one result beat, in order; loads give no result. Every entry a query touches
// must have been loaded first. One beat of either kind is accepted per cycle when
// nothing stalls: the store is kept in two copies with two read ports each, so all
// four taps of a query are read in the same cycle. Each of the three fields passes
// through its own 37-stage, bit-per-stage divider that forms sum / divisor; a four-entry
// queue between the address front end and the datapath keeps input accepted while
// output is stalled, until it fills. The store has no clearing pass. Registers are
// to be written through the cfg port only while idle; the block does not enforce it.
module motion_vector_field_upsample import mvfu_pkg::*; #(
  parameter int unsigned MAX_SRC_BLOCKS = MAX_SRC_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [13:0]          in_src_index,
  input  logic signed [15:0]   in_load_vx,
  input  logic signed [15:0]   in_load_vy,
  input  logic [15:0]          in_load_sad,
  input  logic [9:0]           in_fine_col,
  input  logic [9:0]           in_fine_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_vx,
  output logic signed [31:0]   out_vy,
  output logic [27:0]          out_sad,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t   cfg_r;
  qstat_t qs;
  logic   push, pop;
  item_t  push_item, pop_item;
  logic [RES_W-1:0] vx_w, vy_w;

  // Register file; always ready, unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width    <= 8'd1;
      cfg_r.src_height   <= 8'd1;
      cfg_r.norm_shift   <= 5'd0;
      cfg_r.divisor      <= 16'd16;
      cfg_r.weight_total <= 8'd4;
      cfg_r.weight_odd   <= 8'd3;
      cfg_r.weight_even  <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:    cfg_r.src_width    <= cfg_data[7:0];
        REG_SRC_HEIGHT:   cfg_r.src_height   <= cfg_data[7:0];
        REG_NORM_SHIFT:   cfg_r.norm_shift   <= cfg_data[4:0];
        REG_DIVISOR:      cfg_r.divisor      <= cfg_data;
        REG_WEIGHT_TOTAL: cfg_r.weight_total <= cfg_data[7:0];
        REG_WEIGHT_ODD:   cfg_r.weight_odd   <= cfg_data[7:0];
        REG_WEIGHT_EVEN:  cfg_r.weight_even  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front end: clamp the fine block, compute the four entry addresses.
  mvfu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_src_index (in_src_index),
    .in_load_vx   (in_load_vx),
    .in_load_vy   (in_load_vy),
    .in_load_sad  (in_load_sad),
    .in_fine_col  (in_fine_col),
    .in_fine_row  (in_fine_row),
    .qs           (qs),
    .push         (push),
    .push_item    (push_item)
  );

  // Decouple front and back so each side can hold on its own.
  mvfu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qs        (qs)
  );

  // Back end: store writes, tap reads, weighting, divide and shift.
  mvfu_back #(
    .MAX_SRC_BLOCKS (MAX_SRC_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .qs        (qs),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_vx    (vx_w),
    .out_vy    (vy_w),
    .out_sad   (out_sad)
  );

  assign out_vx = $signed(vx_w);
  assign out_vy = $signed(vy_w);

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid) else $error("result beat valid right after reset");

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(qs.full && qs.empty)) else $error("queue both full and empty");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> qs.full) else $error("input held while queue can take it");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvfu_pkg::*;

  localparam int STORE_N = 16384;
  localparam int LIMIT   = 600000;
  localparam int DRAIN   = 60;  // result latency plus the queue, with margin

  logic clk, rst_n;
  logic in_valid, in_stall, in_command;
  logic [13:0] in_src_index;
  logic signed [15:0] in_load_vx, in_load_vy;
  logic [15:0] in_load_sad;
  logic [9:0] in_fine_col, in_fine_row;
  logic out_valid, out_stall;
  logic signed [31:0] out_vx, out_vy;
  logic [27:0] out_sad;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  motion_vector_field_upsample DUT (.*);

  // One input beat, with an optional hand-typed expectation for queries.
  typedef struct {
    cmd_t cmd;
    logic [13:0] idx;
    logic [15:0] vx, vy, sad;
    logic [9:0] col, row;
    bit typed;
    logic [31:0] evx, evy;
    logic [27:0] esad;
  } beat_t;

  typedef struct {
    logic [31:0] vx, vy;
    logic [27:0] sad;
  } mv_result_t;

  // Shadow of the register file and the vector store.
  logic [7:0]  r_width, r_height, r_total, r_odd, r_even;
  logic [4:0]  r_shift;
  logic [15:0] r_div;
  logic [15:0] sh_vx [STORE_N];
  logic [15:0] sh_vy [STORE_N];
  logic [15:0] sh_sad [STORE_N];
  bit          loaded [STORE_N];

  mv_result_t pending_q[$];
  int n_err = 0;
  int cyc = 0;
  bit hold_req = 0;   // ask the receiver for one long hold-off
  bit rx_busy = 1;    // receiver stalls at random
  bit tx_busy = 1;    // sender idles at random
  beat_t dir_rows[8];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard stop: no correct run comes near this.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Find the four tap addresses of a fine block under the current geometry.
  function automatic void find_taps(input logic [9:0] col, row, output int addr[4]);
    int w, h, i, j, ox, oy, ip, jp, a;
    bit ce, re;
    w = (r_width == 0) ? 1 : r_width;
    h = (r_height == 0) ? 1 : r_height;
    i = col;
    j = row;
    if (i >= 2 * w) i = 2 * w - 1;
    if (j >= 2 * h) j = 2 * h - 1;
    ox = i[0] ? 1 : -1;
    oy = j[0] ? 1 : -1;
    ip = i >> 1;
    jp = j >> 1;
    ce = (i == 0) || (i >= 2 * w - 1);
    re = (j == 0) || (j >= 2 * h - 1);
    a = ip + jp * w;
    addr[0] = a;
    if (ce && re) begin
      addr[1] = a; addr[2] = a; addr[3] = a;
    end else if (ce) begin
      addr[1] = a; addr[2] = ip + (jp + oy) * w; addr[3] = addr[2];
    end else if (re) begin
      addr[1] = a; addr[2] = ip + ox + jp * w; addr[3] = addr[2];
    end else begin
      addr[1] = ip + ox + jp * w;
      addr[2] = ip + (jp + oy) * w;
      addr[3] = ip + ox + (jp + oy) * w;
    end
  endfunction

  // Blend the taps, divide, wrap to 32 bits, then apply the vector shift.
  function automatic mv_result_t blend_block(input logic [9:0] col, row);
    int addr[4];
    longint ax1, ay1, ax2, ay2, dv, s, q;
    longint wt[4];
    longint v;
    logic signed [31:0] wr[3];
    logic signed [4:0] sh;
    logic [31:0] u;
    mv_result_t r;
    find_taps(col, row, addr);
    ax1 = (col >= 2 * ((r_width == 0) ? 1 : r_width)) ? ((((r_width == 0) ? 1 : r_width) * 2 - 1) % 2)
          : col[0];
    ay1 = (row >= 2 * ((r_height == 0) ? 1 : r_height)) ? ((((r_height == 0) ? 1 : r_height) * 2 - 1) % 2)
          : row[0];
    // Clamped coordinate is always odd, so parity above is 1 when clamped.
    ax1 = ax1 ? longint'(r_odd) : longint'(r_even);
    ay1 = ay1 ? longint'(r_odd) : longint'(r_even);
    ax2 = longint'(r_total) - ax1;
    ay2 = longint'(r_total) - ay1;
    wt[0] = ax1 * ay1;
    wt[1] = ax2 * ay1;
    wt[2] = ax1 * ay2;
    wt[3] = ax2 * ay2;
    dv = (r_div == 0) ? 1 : r_div;
    for (int f = 0; f < 3; f++) begin
      s = 0;
      for (int k = 0; k < 4; k++) begin
        if (f == 0) v = longint'($signed(sh_vx[addr[k]]));
        else if (f == 1) v = longint'($signed(sh_vy[addr[k]]));
        else v = longint'(sh_sad[addr[k]]);
        s += wt[k] * v;
      end
      q = s / dv;
      wr[f] = q[31:0];
    end
    sh = r_shift;
    for (int f = 0; f < 2; f++) begin
      if (sh > 0) wr[f] = wr[f] >>> sh;
      else begin
        u = wr[f];
        u = u << (-sh);
        wr[f] = u;
      end
    end
    wr[2] = wr[2] >>> 4;
    r.vx = wr[0];
    r.vy = wr[1];
    r.sad = wr[2][27:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_busy || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Offer one beat, hold it until accepted, then update the shadow state.
  task automatic put_beat(input beat_t b);
    mv_result_t r;
    int g;
    @(negedge clk);
    in_valid = 1;
    in_command = b.cmd;
    in_src_index = b.idx;
    in_load_vx = b.vx;
    in_load_vy = b.vy;
    in_load_sad = b.sad;
    in_fine_col = b.col;
    in_fine_row = b.row;
    do @(posedge clk); while (in_stall);
    if (b.cmd == CMD_LOAD) begin
      sh_vx[b.idx] = b.vx;
      sh_vy[b.idx] = b.vy;
      sh_sad[b.idx] = b.sad;
      loaded[b.idx] = 1;
    end else if (b.typed) begin
      r.vx = b.evx; r.vy = b.evy; r.sad = b.esad;
      pending_q = {pending_q, r};
    end else
      pending_q = {pending_q, blend_block(b.col, b.row)};
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Drop valid so the last beat is not offered again.
  task automatic drop_valid();
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SRC_WIDTH:    r_width = val[7:0];
      REG_SRC_HEIGHT:   r_height = val[7:0];
      REG_NORM_SHIFT:   r_shift = val[4:0];
      REG_DIVISOR:      r_div = val;
      REG_WEIGHT_TOTAL: r_total = val[7:0];
      REG_WEIGHT_ODD:   r_odd = val[7:0];
      REG_WEIGHT_EVEN:  r_even = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Drain every expected beat, then let the pipeline empty out.
  task automatic settle();
    drop_valid();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_regs(input int w, h, sh, dv, tot, od, ev);
    settle();
    write_reg(REG_SRC_WIDTH, 16'(w));
    write_reg(REG_SRC_HEIGHT, 16'(h));
    write_reg(REG_NORM_SHIFT, 16'(sh & 5'h1f));
    write_reg(REG_DIVISOR, 16'(dv));
    write_reg(REG_WEIGHT_TOTAL, 16'(tot));
    write_reg(REG_WEIGHT_ODD, 16'(od));
    write_reg(REG_WEIGHT_EVEN, 16'(ev));
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic beat_t rand_load(input int idx);
    beat_t b;
    b.cmd = CMD_LOAD;
    b.idx = 14'(idx);
    b.vx = rand_val();
    b.vy = rand_val();
    b.sad = rand_val();
    b.col = 10'($urandom());
    b.row = 10'($urandom());
    b.typed = 0;
    return b;
  endfunction

  // Random traffic under the current registers: mostly queries whose taps are
  // loaded first, plus loads inside the field and stray loads anywhere.
  task automatic run_phase(input int n, input bit pressure);
    int w, h, sel, addr[4];
    beat_t b;
    w = (r_width == 0) ? 1 : r_width;
    h = (r_height == 0) ? 1 : r_height;
    for (int k = 0; k < n; k++) begin
      if (pressure && k == n / 3) hold_req = 1;
      if (pressure && k == 2 * n / 3) begin
        drop_valid();
        while (pending_q.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        b = rand_load(0);
        b.cmd = CMD_QUERY;
        if ($urandom_range(0, 9) == 0) begin
          b.col = 10'($urandom());
          b.row = 10'($urandom());
        end else begin
          b.col = 10'($urandom_range(0, 2 * w + 1));
          b.row = 10'($urandom_range(0, 2 * h + 1));
        end
        find_taps(b.col, b.row, addr);
        foreach (addr[t])
          if (!loaded[addr[t]]) put_beat(rand_load(addr[t]));
        put_beat(b);
      end else if (sel < 90)
        put_beat(rand_load($urandom_range(0, w * h - 1)));
      else
        put_beat(rand_load($urandom_range(0, STORE_N - 1)));
    end
  endtask

  // Receiver: random short stalls, occasional long ones, one requested hold-off.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (300) @(negedge clk);
        hold_req = 0;
        out_stall = 0;
      end else if (rx_busy && $urandom_range(0, 59) == 0) begin
        n = $urandom_range(5, 40);
        out_stall = 1;
        repeat (n - 1) @(negedge clk);
      end else
        out_stall = rx_busy ? ($urandom_range(0, 3) == 0) : 0;
    end
  end

  // Check every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    mv_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat vx=%0d vy=%0d sad=%0d",
                                  out_vx, out_vy, out_sad);
      end else begin
        e = pending_q.pop_front();
        if (out_vx !== e.vx || out_vy !== e.vy || out_sad !== e.sad) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp vx=%0d vy=%0d sad=%0d, got vx=%0d vy=%0d sad=%0d",
                     $signed(e.vx), $signed(e.vy), e.sad, out_vx, out_vy, out_sad);
        end
      end
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0; in_command = CMD_LOAD; in_src_index = 0;
    in_load_vx = 0; in_load_vy = 0; in_load_sad = 0;
    in_fine_col = 0; in_fine_row = 0;
    cfg_valid = 0; cfg_index = REG_SRC_WIDTH; cfg_data = 0;
    r_width = 1; r_height = 1; r_shift = 0; r_div = 16;
    r_total = 4; r_odd = 3; r_even = 3;
    foreach (loaded[k]) loaded[k] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed beats under reset registers: 1x1 field, weights sum to 16.
    dir_rows[0] = '{CMD_LOAD, 14'd0, 16'h8000, 16'h7fff, 16'hffff, 10'd0, 10'd0,
                    0, 32'd0, 32'd0, 28'd0};
    dir_rows[1] = '{CMD_QUERY, 14'd0, 16'h0, 16'h0, 16'h0, 10'd0, 10'd0,
                    1, -32'sd32768, 32'sd32767, 28'd4095};
    dir_rows[2] = '{CMD_QUERY, 14'h3fff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff,
                    1, -32'sd32768, 32'sd32767, 28'd4095};
    dir_rows[3] = '{CMD_LOAD, 14'h3fff, 16'h1234, 16'h8000, 16'h0001, 10'h3ff, 10'd0,
                    0, 32'd0, 32'd0, 28'd0};
    dir_rows[4] = '{CMD_LOAD, 14'd0, 16'h7fff, 16'h8000, 16'h0000, 10'd0, 10'd0,
                    0, 32'd0, 32'd0, 28'd0};
    dir_rows[5] = '{CMD_QUERY, 14'd0, 16'h0, 16'h0, 16'h0, 10'd1, 10'd0,
                    1, 32'sd32767, -32'sd32768, 28'd0};
    dir_rows[6] = '{CMD_QUERY, 14'd0, 16'h0, 16'h0, 16'h0, 10'd512, 10'd1,
                    0, 32'd0, 32'd0, 28'd0};
    dir_rows[7] = '{CMD_QUERY, 14'd0, 16'h0, 16'h0, 16'h0, 10'd0, 10'h3ff,
                    0, 32'd0, 32'd0, 28'd0};
    foreach (dir_rows[k]) put_beat(dir_rows[k]);

    // Register settings: ordinary, zero size and divisor, widest field with
    // negative partner weights, tall and wide strips, then random.
    set_regs(8, 6, 0, 16, 4, 3, 1);       run_phase(40, 1);
    set_regs(0, 0, -16, 0, 255, 255, 0);  run_phase(20, 0);
    set_regs(128, 128, 15, 65535, 0, 255, 255); run_phase(30, 0);
    set_regs(1, 128, -8, 1, 255, 0, 255); run_phase(30, 0);
    set_regs(128, 1, 8, 3, 7, 5, 2);      run_phase(30, 0);
    for (int p = 0; p < 7; p++) begin
      rx_busy = $urandom_range(0, 3) != 0;
      tx_busy = $urandom_range(0, 3) != 0;
      set_regs($urandom_range(1, 12), $urandom_range(1, 12),
               $signed($urandom_range(0, 16)) - 8, $urandom_range(1, 65535),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      run_phase(30, p == 3);
    end

    @(negedge clk);
    in_valid = 0;
    settle();
    if (n_err == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
